FILE: hw/rtl/stateful_flow_filter_macros.svh
// Assertion macros used by the checker file of the flow filter.
`ifndef STATEFUL_FLOW_FILTER_MACROS_SVH
`define STATEFUL_FLOW_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFF_ASSERT_SAME(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("flow filter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFF_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("flow filter assertion failed");

`endif

FILE: hw/rtl/sff_pkg.sv
package sff_pkg;

  localparam int DEF_RULE_ENTRIES = 64;
  localparam int DEF_FLOW_ENTRIES = 1024;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [1:0] REQ_PACKET    = 2'd0;
  localparam logic [1:0] REQ_RULE3     = 2'd1;
  localparam logic [1:0] REQ_RULE5     = 2'd2;
  localparam logic [1:0] REQ_FLOW_READ = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_MISS = 2'd2;

  // Rule action that turns into a drop verdict.
  localparam logic ACTION_DROP = 1'b0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  pkt_flags;
    logic [63:0] now_ns;
    logic        rule_action;
    logic        key_sym;
  } job_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        verdict;
    logic        rule_hit;
    logic        flow_created;
    logic [7:0]  flow_flags;
    logic [63:0] flow_count;
    logic [63:0] flow_time;
  } res_t;

endpackage

FILE: hw/rtl/sff_front.sv
module sff_front import sff_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  protocol,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [7:0]  pkt_flags,
  input  logic [63:0] now_ns,
  input  logic        rule_action,
  input  logic        q_full,
  output logic        push,
  output job_t        push_job
);

  logic held;
  logic accept;
  job_t job;

  // The held word waits here only while the queue is full.
  assign req_stall = held & q_full;
  assign push      = held & ~q_full;
  assign accept    = req_valid & ~req_stall;
  assign push_job  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= accept | (held & q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job.req_type    <= req_type;
      job.protocol    <= protocol;
      job.src_ip      <= src_ip;
      job.dst_ip      <= dst_ip;
      job.src_port    <= src_port;
      job.dst_port    <= dst_port;
      job.pkt_flags   <= pkt_flags;
      job.now_ns      <= now_ns;
      job.rule_action <= rule_action;
      // Reverse key equals forward key when both ends are the same.
      job.key_sym     <= (src_ip == dst_ip) && (src_port == dst_port);
    end
  end

endmodule

FILE: hw/rtl/sff_queue.sv
module sff_queue import sff_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t pop_job
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & q_valid;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: hw/rtl/sff_back.sv
module sff_back import sff_pkg::*; #(
  parameter int RULE_ENTRIES = DEF_RULE_ENTRIES,
  parameter int FLOW_ENTRIES = DEF_FLOW_ENTRIES
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  job_t q_job,
  output logic pop,
  output logic rsp_valid,
  input  logic rsp_stall,
  output res_t rsp
);

  localparam int RAW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
  localparam int RCW = $clog2(RULE_ENTRIES + 1);
  localparam int FAW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int FCW = $clog2(FLOW_ENTRIES + 1);
  localparam int SW  = (RCW > FCW) ? RCW : FCW;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN3    = 3'd1;
  localparam logic [2:0] S_SCAN5    = 3'd2;
  localparam logic [2:0] S_SCANF    = 3'd3;
  localparam logic [2:0] S_RULE_WR  = 3'd4;
  localparam logic [2:0] S_FLOW_UPD = 3'd5;
  localparam logic [2:0] S_FLOW_REV = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  typedef struct packed {
    logic [63:0] addr;
    logic [7:0]  protocol;
    logic        action;
  } r3_entry_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic        action;
  } r5_entry_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
  } flow_key_t;

  typedef struct packed {
    flow_key_t   key;
    logic [63:0] last_time;
    logic [7:0]  flags;
    logic [63:0] packets;
  } flow_entry_t;

  r3_entry_t   r3_mem [RULE_ENTRIES];
  r5_entry_t   r5_mem [RULE_ENTRIES];
  flow_entry_t fl_mem [FLOW_ENTRIES];

  r3_entry_t   r3_rd;
  r5_entry_t   r5_rd;
  flow_entry_t fl_rd;

  logic [2:0]     state;
  job_t           job;
  logic [SW-1:0]  scan_cnt;
  logic [SW-1:0]  rd_idx;
  logic           rd_pend;
  logic [RCW-1:0] fill3;
  logic [RCW-1:0] fill5;
  logic [FCW-1:0] fillf;
  logic           m_found;
  logic           m_act;
  logic [SW-1:0]  m_idx;
  flow_entry_t    m_flow;
  logic           rv_found;
  logic [SW-1:0]  rv_idx;
  logic           pkt_hit;
  logic           pkt_act;
  logic           fwd_ok;
  logic [FAW-1:0] fwd_idx;
  res_t           res;

  flow_key_t      fwd_key;
  flow_key_t      rev_key;
  logic [SW-1:0]  cur_fill;
  logic           issue;
  logic           scan_done;
  logic           r3_hit;
  logic           r5_hit;
  logic           ff_hit;
  logic           fr_hit;
  logic           room3;
  logic           room5;
  logic           roomf;
  logic           hit_all;
  logic           act_all;
  logic           out_free;

  logic           r3_we;
  logic [RAW-1:0] r3_wa;
  r3_entry_t      r3_wd;
  logic           r5_we;
  logic [RAW-1:0] r5_wa;
  r5_entry_t      r5_wd;
  logic           fl_we;
  logic [FAW-1:0] fl_wa;
  flow_entry_t    fl_wd;

  assign fwd_key = '{addr: {job.src_ip, job.dst_ip}, src_port: job.src_port,
                     dst_port: job.dst_port, protocol: job.protocol};
  assign rev_key = '{addr: {job.dst_ip, job.src_ip}, src_port: job.dst_port,
                     dst_port: job.src_port, protocol: job.protocol};

  always_comb begin
    unique case (state)
      S_SCAN3: cur_fill = SW'(fill3);
      S_SCAN5: cur_fill = SW'(fill5);
      S_SCANF: cur_fill = SW'(fillf);
      default: cur_fill = '0;
    endcase
  end

  assign issue     = (scan_cnt < cur_fill);
  assign scan_done = ~issue & ~rd_pend;

  assign r3_hit = (r3_rd.addr == fwd_key.addr) && (r3_rd.protocol == job.protocol);
  assign r5_hit = (r5_rd.addr == fwd_key.addr) && (r5_rd.protocol == job.protocol) &&
                  (r5_rd.src_port == job.src_port) && (r5_rd.dst_port == job.dst_port);
  assign ff_hit = (fl_rd.key == fwd_key);
  assign fr_hit = (fl_rd.key == rev_key);

  assign room3 = (fill3 != RCW'(RULE_ENTRIES));
  assign room5 = (fill5 != RCW'(RULE_ENTRIES));
  assign roomf = (fillf != FCW'(FLOW_ENTRIES));

  // A five-tuple hit overrides the action of a three-tuple hit.
  assign hit_all = pkt_hit | m_found;
  assign act_all = m_found ? m_act : pkt_act;

  assign out_free = ~rsp_valid | ~rsp_stall;
  assign pop      = (state == S_IDLE) & q_valid;

  always_comb begin
    r3_we = 1'b0;
    r3_wa = m_found ? m_idx[RAW-1:0] : fill3[RAW-1:0];
    r3_wd = '{addr: fwd_key.addr, protocol: job.protocol, action: job.rule_action};
    r5_we = 1'b0;
    r5_wa = m_found ? m_idx[RAW-1:0] : fill5[RAW-1:0];
    r5_wd = '{addr: fwd_key.addr, src_port: job.src_port, dst_port: job.dst_port,
              protocol: job.protocol, action: job.rule_action};
    fl_we = 1'b0;
    fl_wa = fillf[FAW-1:0];
    fl_wd = '{key: rev_key, last_time: '0, flags: '0, packets: '0};
    if (state == S_RULE_WR) begin
      r3_we = (job.req_type == REQ_RULE3) && (m_found || room3);
      r5_we = (job.req_type == REQ_RULE5) && (m_found || room5);
    end
    if (state == S_FLOW_UPD) begin
      if (m_found) begin
        fl_we = 1'b1;
        fl_wa = m_idx[FAW-1:0];
        fl_wd = '{key: m_flow.key, last_time: job.now_ns,
                  flags: m_flow.flags | job.pkt_flags,
                  packets: m_flow.packets + 64'd1};
      end else begin
        fl_we = roomf;
        fl_wd = '{key: fwd_key, last_time: job.now_ns, flags: job.pkt_flags,
                  packets: 64'd1};
      end
    end
    if (state == S_FLOW_REV) begin
      priority if (rv_found) begin
        fl_we = 1'b1;
        fl_wa = rv_idx[FAW-1:0];
      end else if (job.key_sym && fwd_ok) begin
        fl_we = 1'b1;
        fl_wa = fwd_idx;
      end else begin
        fl_we = roomf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r3_we) begin
      r3_mem[r3_wa] <= r3_wd;
    end
    r3_rd <= r3_mem[scan_cnt[RAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (r5_we) begin
      r5_mem[r5_wa] <= r5_wd;
    end
    r5_rd <= r5_mem[scan_cnt[RAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (fl_we) begin
      fl_mem[fl_wa] <= fl_wd;
    end
    fl_rd <= fl_mem[scan_cnt[FAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      scan_cnt  <= '0;
      rd_pend   <= 1'b0;
      fill3     <= '0;
      fill5     <= '0;
      fillf     <= '0;
    end else begin
      // The response register fills in the done state and empties when taken.
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      // Shared scan engine: one entry read per cycle, compared in the next cycle.
      if (state == S_SCAN3 || state == S_SCAN5 || state == S_SCANF) begin
        rd_pend <= issue;
        rd_idx  <= scan_cnt;
        if (issue) begin
          scan_cnt <= scan_cnt + SW'(1);
        end
        if (rd_pend) begin
          if (state == S_SCAN3 && r3_hit) begin
            m_found <= 1'b1;
            m_idx   <= rd_idx;
            m_act   <= r3_rd.action;
          end
          if (state == S_SCAN5 && r5_hit) begin
            m_found <= 1'b1;
            m_idx   <= rd_idx;
            m_act   <= r5_rd.action;
          end
          if (state == S_SCANF && ff_hit) begin
            m_found <= 1'b1;
            m_idx   <= rd_idx;
            m_flow  <= fl_rd;
          end
          if (state == S_SCANF && fr_hit) begin
            rv_found <= 1'b1;
            rv_idx   <= rd_idx;
          end
        end
      end

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            job      <= q_job;
            res      <= '0;
            m_found  <= 1'b0;
            rv_found <= 1'b0;
            fwd_ok   <= 1'b0;
            scan_cnt <= '0;
            rd_pend  <= 1'b0;
            unique case (q_job.req_type)
              REQ_PACKET:    state <= S_SCAN3;
              REQ_RULE3:     state <= S_SCAN3;
              REQ_RULE5:     state <= S_SCAN5;
              REQ_FLOW_READ: state <= S_SCANF;
              default:       state <= S_IDLE;
            endcase
          end
        end
        S_SCAN3: begin
          if (scan_done) begin
            scan_cnt <= '0;
            if (job.req_type == REQ_PACKET) begin
              pkt_hit <= m_found;
              pkt_act <= m_found ? m_act : 1'b1;
              m_found <= 1'b0;
              state   <= S_SCAN5;
            end else begin
              state <= S_RULE_WR;
            end
          end
        end
        S_SCAN5: begin
          if (scan_done) begin
            scan_cnt <= '0;
            if (job.req_type == REQ_PACKET) begin
              res.rule_hit <= hit_all;
              res.verdict  <= (act_all == ACTION_DROP);
              if (hit_all) begin
                m_found <= 1'b0;
                state   <= S_SCANF;
              end else begin
                state <= S_DONE;
              end
            end else begin
              state <= S_RULE_WR;
            end
          end
        end
        S_SCANF: begin
          if (scan_done) begin
            scan_cnt <= '0;
            if (job.req_type == REQ_PACKET) begin
              state <= S_FLOW_UPD;
            end else begin
              if (m_found) begin
                res.flow_flags <= m_flow.flags;
                res.flow_count <= m_flow.packets;
                res.flow_time  <= m_flow.last_time;
              end else begin
                res.status <= STATUS_MISS;
              end
              state <= S_DONE;
            end
          end
        end
        S_RULE_WR: begin
          if (job.req_type == REQ_RULE3) begin
            if (!m_found && room3) begin
              fill3 <= fill3 + RCW'(1);
            end else if (!m_found) begin
              res.status <= STATUS_FULL;
            end
          end else begin
            if (!m_found && room5) begin
              fill5 <= fill5 + RCW'(1);
            end else if (!m_found) begin
              res.status <= STATUS_FULL;
            end
          end
          state <= S_DONE;
        end
        S_FLOW_UPD: begin
          if (m_found) begin
            res.flow_flags <= m_flow.flags | job.pkt_flags;
            res.flow_count <= m_flow.packets + 64'd1;
            res.flow_time  <= job.now_ns;
            state          <= S_DONE;
          end else begin
            if (roomf) begin
              fwd_ok           <= 1'b1;
              fwd_idx          <= fillf[FAW-1:0];
              fillf            <= fillf + FCW'(1);
              res.flow_created <= 1'b1;
              // A symmetric key is zeroed again by the reverse write.
              if (!job.key_sym) begin
                res.flow_flags <= job.pkt_flags;
                res.flow_count <= 64'd1;
                res.flow_time  <= job.now_ns;
              end
            end else begin
              res.status <= STATUS_FULL;
            end
            state <= S_FLOW_REV;
          end
        end
        S_FLOW_REV: begin
          if (!rv_found && !(job.key_sym && fwd_ok)) begin
            if (roomf) begin
              fillf <= fillf + FCW'(1);
            end else begin
              res.status <= STATUS_FULL;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/stateful_flow_filter.sv
// Stateful five-tuple filter for parsed IPv4 headers. Each request word is a
// packet to classify, a three-tuple or five-tuple rule to install, or a flow
// entry to read back, and each gives exactly one response word. A front stage
// registers the request and places it in a two-word queue, so the block takes
// new requests while the back end works and while a response waits. The back
// end searches its tables with a single-ported linear scan, one entry per
// clock, over only the entries in use. A packet scans the three-tuple and
// then the five-tuple table; on a rule hit it also scans the flow table,
// then updates its flow entry, or creates it and writes a reverse entry.
// A rule write scans its own table before the write, and a flow read scans
// the flow table. A stalled response can hold the back end.
// Entries are never removed, so tables fill from the lowest index and a fill
// count marks the live entries: there is no clearing pass after reset, and
// requests are taken from the first cycle after reset. A full table drops the
// insert and reports status 1; a failed flow read reports status 2.
module stateful_flow_filter import sff_pkg::*; #(
  parameter int RULE_ENTRIES = DEF_RULE_ENTRIES,
  parameter int FLOW_ENTRIES = DEF_FLOW_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  protocol,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [7:0]  pkt_flags,
  input  logic [63:0] now_ns,
  input  logic        rule_action,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic        verdict,
  output logic        rule_hit,
  output logic        flow_created,
  output logic [7:0]  flow_flags,
  output logic [63:0] flow_count,
  output logic [63:0] flow_time
);

  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  logic pop;
  job_t pop_job;
  res_t rsp;

  // The front registers one word and hands it on once the queue has room.
  sff_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .protocol    (protocol),
    .src_ip      (src_ip),
    .dst_ip      (dst_ip),
    .src_port    (src_port),
    .dst_port    (dst_port),
    .pkt_flags   (pkt_flags),
    .now_ns      (now_ns),
    .rule_action (rule_action),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  sff_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_job  (pop_job)
  );

  // The back end owns all tables and the response register.
  sff_back #(
    .RULE_ENTRIES (RULE_ENTRIES),
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  assign status       = rsp.status;
  assign verdict      = rsp.verdict;
  assign rule_hit     = rsp.rule_hit;
  assign flow_created = rsp.flow_created;
  assign flow_flags   = rsp.flow_flags;
  assign flow_count   = rsp.flow_count;
  assign flow_time    = rsp.flow_time;

endmodule

FILE: hw/rtl/sff_checker.sv
`include "stateful_flow_filter_macros.svh"

module sff_checker import sff_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [1:0]  status,
  input logic        verdict,
  input logic        rule_hit,
  input logic        flow_created,
  input logic [7:0]  flow_flags,
  input logic [63:0] flow_count,
  input logic [63:0] flow_time
);

  logic [140:0] rsp_word;
  logic         stalled;
  logic         missed;
  logic         flow_clear;

  assign rsp_word   = {status, verdict, rule_hit, flow_created, flow_flags,
                       flow_count, flow_time};
  assign stalled    = rsp_valid && rsp_stall;
  assign missed     = rsp_valid && (status == STATUS_MISS);
  assign flow_clear = !rule_hit && (flow_count == 64'd0) && (flow_time == 64'd0);

  // A stalled response word stays and keeps its value.
  `SFF_ASSERT_NEXT(a_rsp_hold, clk, rst, stalled, rsp_valid)
  `SFF_ASSERT_NEXT(a_rsp_stable, clk, rst, stalled, $stable(rsp_word))

  // No response right after reset.
  `SFF_ASSERT_NEXT(a_rst_quiet, clk, 1'b0, rst, !rsp_valid)

  // Drop and flow creation need a rule hit; the default is accept.
  `SFF_ASSERT_SAME(a_hit_needed, clk, rst, rsp_valid && (verdict || flow_created), rule_hit)

  // A missed flow read carries no packet results and no counters.
  `SFF_ASSERT_SAME(a_miss_clean, clk, rst, missed, flow_clear)

endmodule

bind stateful_flow_filter sff_checker u_sff_checker (.*);
